FILE: hw/rtl/positional_ordered_list_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional ordered list unit
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POLU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("positional ordered list unit: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define POLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("positional ordered list unit: assertion failed");

`endif

FILE: hw/rtl/polu_pkg.sv
// ---------------------------------------------------------------------------
// polu_pkg
// Command, status and chain-operation codes and the chain control type.
// ---------------------------------------------------------------------------
`default_nettype none

package polu_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 7;

	localparam logic [2:0] CMD_INS_HEAD = 3'd0;
	localparam logic [2:0] CMD_INS_TAIL = 3'd1;
	localparam logic [2:0] CMD_INS_AT   = 3'd2;
	localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
	localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
	localparam logic [2:0] CMD_DEL_AT   = 3'd5;
	localparam logic [2:0] CMD_COUNT    = 3'd6;
	localparam logic [2:0] CMD_DUMP     = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_ROT  = 2'd3;

	// slot: insert/delete slot, or the tail slot for a rotate
	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] slot;
	} chain_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_ordered_list_unit.sv
// ---------------------------------------------------------------------------
// positional_ordered_list_unit
// Ordered list of signed 32-bit values kept in a chain of shifting cells.
// ---------------------------------------------------------------------------
//   channel | handshake            | fields
//   --------+----------------------+---------------------------------------------
//   in      | in_valid, in_ready   | command, value, position
//   out     | out_valid, out_ready | element, element_index, length, status, last
//
// Insert, delete and count requests are taken back to back while the output
// register drains. A dump of n elements returns n results, one result per
// cycle while out is not stalled, each taken from the head as the chain rotates
// by one step; no request is taken until the last element has been sent.
// Reset clears the count and all control state; cell contents are not reset.
// A stall on out holds the output register and the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_ordered_list_unit #(
	parameter int CAPACITY = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [2:0]           command,
	input  wire logic signed [31:0]   value,
	input  wire logic [6:0]           position,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        element,
	output logic [6:0]                element_index,
	output logic [6:0]                length,
	output logic [1:0]                status,
	output logic                      last
);
	import polu_pkg::*;

	`include "positional_ordered_list_unit_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     dmp_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] element_q;
	logic [6:0]        element_index_q;
	logic [6:0]        length_q;
	logic [1:0]        status_q;
	logic              last_q;

	logic              accept;
	logic              out_free;
	logic              dump_step;
	logic              dump_last;
	logic [6:0]        cnt7;
	logic [7:0]        pos8;
	logic [7:0]        cnt8;
	logic              full;
	logic              empty;
	logic [1:0]        st;
	logic              change;
	logic              is_ins;
	logic [6:0]        slot;
	logic              start_dump;
	logic [CW-1:0]     cnt_next;
	chain_ctrl_t       ctrl;

	logic [DATA_W-1:0] cell_val [CAPACITY];

	assign cnt7  = 7'(cnt_q);
	assign cnt8  = {1'b0, cnt7};
	assign pos8  = {1'b0, position};
	assign full  = (cnt_q == CAP_V);
	assign empty = (cnt_q == '0);

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !busy_q && out_free;
	assign accept    = in_valid && in_ready;
	assign dump_step = busy_q && out_free;
	assign dump_last = ((dmp_q + CW'(1)) == cnt_q);

	// decode the request: status, chain action and slot
	always_comb begin
		st         = ST_OK;
		change     = 1'b0;
		is_ins     = 1'b0;
		slot       = '0;
		start_dump = 1'b0;
		case (command)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				is_ins = 1'b1;
				if (full) begin
					st = ST_FULL;
				end else if (command == CMD_INS_HEAD) begin
					change = 1'b1;
				end else if (command == CMD_INS_TAIL) begin
					change = 1'b1;
					slot   = cnt7;
				end else if (position == '0 || pos8 > cnt8 + 8'd1) begin
					st = ST_RANGE;
				end else begin
					change = 1'b1;
					slot   = position - 7'd1;
				end
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (command == CMD_DEL_HEAD) begin
					change = 1'b1;
				end else if (command == CMD_DEL_TAIL) begin
					change = 1'b1;
					slot   = cnt7 - 7'd1;
				end else if (position == '0 || pos8 > cnt8) begin
					st = ST_RANGE;
				end else begin
					change = 1'b1;
					slot   = position - 7'd1;
				end
			end
			CMD_COUNT: st = ST_OK;
			CMD_DUMP: begin
				if (empty)
					st = ST_EMPTY;
				else
					start_dump = 1'b1;
			end
			default: st = ST_OK;
		endcase
	end

	always_comb begin
		ctrl.op   = OP_HOLD;
		ctrl.slot = slot;
		if (accept && change) begin
			ctrl.op = is_ins ? OP_INS : OP_DEL;
		end else if (dump_step) begin
			ctrl.op   = OP_ROT;
			ctrl.slot = cnt7 - 7'd1;
		end
	end

	assign cnt_next = is_ins ? cnt_q + CW'(1) : cnt_q - CW'(1);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;
		if (g == 0) begin : g_first
			assign left_v = value;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_final
			assign right_v = cell_val[0];
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end
		polu_cell #(
			.IDX(g)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_val   (value),
			.left_val  (left_v),
			.right_val (right_v),
			.head_val  (cell_val[0]),
			.val       (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			dmp_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && change)
				cnt_q <= cnt_next;
			if (accept && start_dump) begin
				busy_q <= 1'b1;
				dmp_q  <= '0;
			end else if (dump_step) begin
				dmp_q <= dmp_q + CW'(1);
				if (dump_last)
					busy_q <= 1'b0;
			end
			if ((accept && !start_dump) || dump_step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload; length is the count after the request
	always_ff @(posedge clk) begin
		if (dump_step) begin
			element_q       <= cell_val[0];
			element_index_q <= 7'(dmp_q) + 7'd1;
			length_q        <= cnt7;
			status_q        <= ST_OK;
			last_q          <= dump_last;
		end else if (accept && !start_dump) begin
			element_q       <= '0;
			element_index_q <= '0;
			length_q        <= (change) ? 7'(cnt_next) : cnt7;
			status_q        <= st;
			last_q          <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign element       = element_q;
	assign element_index = element_index_q;
	assign length        = length_q;
	assign status        = status_q;
	assign last          = last_q;

	`POLU_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CAP_V)
	`POLU_ASSERT_NEXT(a_full_ins_keeps, clk, arst_n, accept && is_ins && full, cnt_q == CAP_V)
	`POLU_ASSERT_NEXT(a_dump_ends, clk, arst_n, dump_step && dump_last, !busy_q && last_q)
	`POLU_ASSERT_NOW(a_empty_len, clk, arst_n, out_valid_q && status_q == ST_EMPTY, length_q == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/polu_cell.sv
// ---------------------------------------------------------------------------
// polu_cell
// One storage cell of the list chain: holds, shifts or loads its entry.
// ---------------------------------------------------------------------------
`default_nettype none

module polu_cell #(
	parameter int IDX = 0
) (
	input  wire logic                              clk,
	input  wire polu_pkg::chain_ctrl_t             ctrl,
	input  wire logic [polu_pkg::DATA_W-1:0]       new_val,
	input  wire logic [polu_pkg::DATA_W-1:0]       left_val,
	input  wire logic [polu_pkg::DATA_W-1:0]       right_val,
	input  wire logic [polu_pkg::DATA_W-1:0]       head_val,
	output logic      [polu_pkg::DATA_W-1:0]       val
);
	import polu_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] nxt;

	always_comb begin
		nxt = val_q;
		case (ctrl.op)
			OP_INS: begin
				if (MY_IDX > ctrl.slot)
					nxt = left_val;
				else if (MY_IDX == ctrl.slot)
					nxt = new_val;
			end
			OP_DEL: begin
				if (MY_IDX >= ctrl.slot)
					nxt = right_val;
			end
			OP_ROT: begin
				// tail takes the head, everything in front moves one toward the head
				if (MY_IDX == ctrl.slot)
					nxt = head_val;
				else if (MY_IDX < ctrl.slot)
					nxt = right_val;
			end
			default: nxt = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

	assign val = val_q;

endmodule

`default_nettype wire
